### rtl/wsht_pkg.sv
`default_nettype none

package wsht_pkg;

	// width of the reported window number
	localparam int unsigned ID_W = 5;

	// operation codes on the input channel
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_CLICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEL,
		ST_MOVE,
		ST_DONE
	} wsht_state_t;

	typedef struct packed {
		logic latch;
		logic load;
		logic cmp;
		logic sel;
		logic swap;
		logic emit;
	} wsht_cmd_t;

	typedef struct packed {
		logic hit;
		logic at_top;
	} wsht_sts_t;

endpackage

`default_nettype wire

### rtl/wsht_ctrl.sv
`default_nettype none

module wsht_ctrl
	import wsht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      operation,
	input  wire logic      out_free,
	input  wire wsht_sts_t sts,
	output logic           in_stall,
	output wsht_cmd_t      cmd
);

	wsht_state_t state_q, state_d;
	logic        accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_CLICK)) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP:  state_d = ST_SEL;
			ST_SEL:  state_d = sts.hit ? ST_MOVE : ST_DONE;
			ST_MOVE: begin
				if (sts.at_top) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = accept;
				cmd.load  = accept && (operation == OP_LOAD);
			end
			ST_CMP:  cmd.cmp  = 1'b1;
			ST_SEL:  cmd.sel  = 1'b1;
			ST_MOVE: cmd.swap = !sts.at_top;
			ST_DONE: cmd.emit = out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/wsht_dpath.sv
`default_nettype none

module wsht_dpath
	import wsht_pkg::*;
#(
	parameter int unsigned MAX_WINDOWS = 16,
	parameter int unsigned COORD_BITS  = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wsht_cmd_t             cmd,
	input  wire logic [COORD_BITS-1:0] point_x,
	input  wire logic [COORD_BITS-1:0] point_y,
	input  wire logic [COORD_BITS-1:0] upper_x,
	input  wire logic [COORD_BITS-1:0] upper_y,
	output wsht_sts_t                  sts,
	output logic                       res_hit,
	output logic [ID_W-1:0]            res_id
);

	localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1);

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] bottom;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] top;
		logic [CNT_W-1:0]      num;
	} entry_t;

	entry_t                  entry_q [MAX_WINDOWS];
	logic [CNT_W-1:0]        count_q;
	logic [COORD_BITS-1:0]   px_q, py_q;
	logic [MAX_WINDOWS-1:0]  match_s1;
	logic [MAX_WINDOWS-1:0]  pos_q;
	logic [MAX_WINDOWS-1:0]  match_d, top_oh, pos_up, wr_sel;
	logic [MAX_WINDOWS-1:0]  rev, rev_iso, top_hit;
	logic                    full;
	entry_t                  new_entry;
	logic [CNT_W-1:0]        id_or;
	logic [CNT_W+ID_W-1:0]   id_ext;

	assign full   = (count_q == CNT_W'(MAX_WINDOWS));
	assign pos_up = pos_q << 1;

	assign new_entry.left   = point_x;
	assign new_entry.bottom = point_y;
	assign new_entry.right  = upper_x;
	assign new_entry.top    = upper_y;
	assign new_entry.num    = count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	// one cell per stack slot: parallel compare, neighbor swap for the raise
	for (genvar j = 0; j < MAX_WINDOWS; j++) begin : g_cell
		entry_t up_w, dn_w;

		if (j < MAX_WINDOWS - 1) begin : g_up
			assign up_w = entry_q[j+1];
		end else begin : g_up_edge
			assign up_w = entry_q[j];
		end
		if (j > 0) begin : g_dn
			assign dn_w = entry_q[j-1];
		end else begin : g_dn_edge
			assign dn_w = entry_q[j];
		end

		assign wr_sel[j]  = !full && (count_q == CNT_W'(j));
		assign top_oh[j]  = (count_q == CNT_W'(j + 1));
		assign match_d[j] = (CNT_W'(j) < count_q)
			&& (px_q >= entry_q[j].left) && (px_q <= entry_q[j].right)
			&& (py_q >= entry_q[j].bottom) && (py_q <= entry_q[j].top);
		assign rev[j]     = match_s1[MAX_WINDOWS-1-j];
		assign top_hit[j] = rev_iso[MAX_WINDOWS-1-j];

		always_ff @(posedge clk) begin
			if (cmd.load && wr_sel[j]) begin
				entry_q[j] <= new_entry;
			end else if (cmd.swap && pos_q[j]) begin
				entry_q[j] <= up_w;
			end else if (cmd.swap && pos_up[j]) begin
				entry_q[j] <= dn_w;
			end
		end
	end

	// isolate the topmost match
	assign rev_iso = rev & (~rev + MAX_WINDOWS'(1));

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			match_s1 <= match_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.sel) begin
			pos_q <= top_hit;
		end else if (cmd.swap) begin
			pos_q <= pos_up;
		end
	end

	always_comb begin
		id_or = '0;
		for (int j = 0; j < MAX_WINDOWS; j++) begin
			id_or = id_or | (entry_q[j].num & {CNT_W{pos_q[j]}});
		end
	end

	assign id_ext     = {ID_W'(0), id_or};
	assign res_id     = id_ext[ID_W-1:0];
	assign res_hit    = |pos_q;
	assign sts.hit    = |match_s1;
	assign sts.at_top = |(pos_q & top_oh);

	a_pos_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pos_q))
		else $error("hit position tracker is not one-hot");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOWS))
		else $error("window count past capacity");

	a_swap_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap |-> ((pos_q != '0) && !sts.at_top && !cmd.load))
		else $error("swap without a hit window below the top");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && full) |=> (count_q == CNT_W'(MAX_WINDOWS)))
		else $error("load on a full stack changed the count");

endmodule

`default_nettype wire

### rtl/window_stack_hit_test_raise_core.sv
`default_nettype none

// channel | signals                                         | role
// in      | in_valid, in_stall, operation, point_x..upper_y | load or click, one per transfer
// out     | out_valid, out_stall, hit, window_id            | one result per click, none per load
//
// a load leaves the controller idle, so the next item may follow in the next cycle
// a click holds in_stall through compare, select and emit on a miss, and also
// through the raise on a hit: the raise moves the hit window up one slot a cycle
// the result sits in an output register, so a stall on out only delays the
// click after the one whose result waits
// arst_n clears the stack count, controller and output valid; no clearing pass

module window_stack_hit_test_raise_core
	import wsht_pkg::*;
#(
	parameter int unsigned MAX_WINDOWS = 16,
	parameter int unsigned COORD_BITS  = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  operation,
	input  wire logic [COORD_BITS-1:0] point_x,
	input  wire logic [COORD_BITS-1:0] point_y,
	input  wire logic [COORD_BITS-1:0] upper_x,
	input  wire logic [COORD_BITS-1:0] upper_y,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       hit,
	output logic [ID_W-1:0]            window_id
);

	wsht_cmd_t       cmd;
	wsht_sts_t       sts;
	logic            out_free;
	logic            res_hit;
	logic [ID_W-1:0] res_id;
	logic            out_valid_q;
	logic            hit_q;
	logic [ID_W-1:0] window_id_q;

	// output slot can take a new result when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	// sequencing: idle, compare, priority select, raise, emit
	wsht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.out_free (out_free),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// window cells, count, hit tracking
	wsht_dpath #(
		.MAX_WINDOWS(MAX_WINDOWS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.point_x (point_x),
		.point_y (point_y),
		.upper_x (upper_x),
		.upper_y (upper_y),
		.sts     (sts),
		.res_hit (res_hit),
		.res_id  (res_id)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_q       <= res_hit;
			window_id_q <= res_id;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign window_id = window_id_q;

endmodule

`default_nettype wire

### verif/window_stack_hit_test_raise_core_tb.sv
module window_stack_hit_test_raise_core_tb;
	import wsht_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int COORD_W     = 12;
	localparam int DRAIN_CYCLES = 40;
	localparam int CLICK_TARGET = 1000;

	localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] ux;
		logic [COORD_W-1:0] uy;
	} stim_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [ID_W-1:0]    num;
	} win_rect_t;

	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] id;
	} click_result_t;

	// dut ports, all inputs known from time zero
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = OP_LOAD;
	logic [COORD_W-1:0] point_x = '0;
	logic [COORD_W-1:0] point_y = '0;
	logic [COORD_W-1:0] upper_x = '0;
	logic [COORD_W-1:0] upper_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [ID_W-1:0]    window_id;

	// stimulus waiting for the driver, and click results still to come
	stim_item_t    stim_q[$];
	click_result_t click_results_q[$];
	// rectangles as loaded, in load order, used to aim clicks
	win_rect_t     aim_rects[$];

	// our own copy of the window stack, bottom at index 0
	win_rect_t stack_copy[STACK_DEPTH];
	int        stack_fill = 0;

	// handshake flags, set at the rising edge, read at the falling edge
	logic       in_taken = 1'b0;
	logic       out_taken = 1'b0;
	stim_item_t cur_item = '0;
	int         in_gap = 0;
	int         in_calm = 0;
	int         out_hold = 0;
	int         out_calm = 0;

	int errors = 0;
	int clicks_done = 0;
	int hits_done = 0;
	int loads_kept = 0;
	int loads_dropped = 0;
	int clicks_planned = 0;

	window_stack_hit_test_raise_core #(
		.MAX_WINDOWS(STACK_DEPTH),
		.COORD_BITS (COORD_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.point_x  (point_x),
		.point_y  (point_y),
		.upper_x  (upper_x),
		.upper_y  (upper_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.window_id(window_id)
	);

	always #1 clk = ~clk;

	// wait length per transfer, 0..15, with occasional stretches of no idling
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 60);
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic queue_item(input logic op, input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] ux,
			input logic [COORD_W-1:0] uy);
		stim_item_t it;
		it = '{op, px, py, ux, uy};
		stim_q.push_back(it);
		if (op == OP_LOAD && aim_rects.size() < STACK_DEPTH) begin
			aim_rects.push_back('{px, py, ux, uy, '0});
		end
		if (op == OP_CLICK) begin
			clicks_planned++;
		end
	endtask

	// predicted effect of one accepted transfer on the stack
	task automatic stack_apply(input stim_item_t it);
		win_rect_t     w;
		click_result_t res;
		logic          found;
		int            k;
		int            j;
		if (it.op == OP_LOAD) begin
			// a load into a full stack is dropped without a result
			if (stack_fill < STACK_DEPTH) begin
				stack_copy[stack_fill] = '{it.px, it.py, it.ux, it.uy, ID_W'(stack_fill + 1)};
				stack_fill++;
				loads_kept++;
			end else begin
				loads_dropped++;
			end
		end else begin
			res = '0;
			found = 1'b0;
			// top down; edges inclusive, inverted rectangles never match
			for (k = stack_fill - 1; k >= 0; k--) begin
				w = stack_copy[k];
				if (!found && it.px >= w.left && it.px <= w.right &&
						it.py >= w.bottom && it.py <= w.top) begin
					found = 1'b1;
					// raise to the top, the rest keep their order
					for (j = k; j < stack_fill - 1; j++) begin
						stack_copy[j] = stack_copy[j + 1];
					end
					stack_copy[stack_fill - 1] = w;
					res.hit = 1'b1;
					res.id = w.num;
				end
			end
			click_results_q.push_back(res);
			clicks_done++;
			if (res.hit) begin
				hits_done++;
			end
		end
	endtask

	// driver: payload changes only at the falling edge, held while stalled
	always @(negedge clk) begin : driver
		logic busy;
		if (arst_n) begin
			busy = in_valid && !in_taken;
			if (in_taken) begin
				in_gap = draw_wait(in_calm);
			end
			if (!busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (stim_q.size() > 0) begin
					cur_item = stim_q.pop_front();
					operation <= cur_item.op;
					point_x <= cur_item.px;
					point_y <= cur_item.py;
					upper_x <= cur_item.ux;
					upper_y <= cur_item.uy;
					busy = 1'b1;
				end
			end
			// single assignment so back-to-back transfers keep valid high
			in_valid <= busy;
		end
	end

	// result side back-pressure, drawn after each result transfer
	always @(negedge clk) begin : sink
		if (arst_n) begin
			if (out_taken) begin
				out_hold = draw_wait(out_calm);
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin : monitor
		click_result_t want;
		in_taken = 1'b0;
		out_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				stack_apply(cur_item);
			end
			if (out_valid && !out_stall) begin
				out_taken = 1'b1;
				if (click_results_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result transfer: hit=%0b window_id=%0d",
							hit, window_id);
					end
				end else begin
					want = click_results_q.pop_front();
					if (hit !== want.hit || window_id !== want.id) begin
						errors++;
						if (errors <= 10) begin
							$display("click result mismatch: expected hit=%0b id=%0d, got hit=%0b id=%0d",
								want.hit, want.id, hit, window_id);
						end
					end
				end
			end
		end
	end

	// hard stop if the handshakes hang
	initial begin
		#1000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		win_rect_t          r;
		logic [COORD_W-1:0] lo_x;
		logic [COORD_W-1:0] hi_x;
		logic [COORD_W-1:0] lo_y;
		logic [COORD_W-1:0] hi_y;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		int                 i;
		int                 pick;
		int                 wid;

		// directed: click on an empty stack
		queue_item(OP_CLICK, 12'd2048, 12'd2048, '0, '0);
		// bottom row strip spanning the full x range, hit on its right edge
		queue_item(OP_LOAD, '0, '0, COORD_MAX, '0);
		queue_item(OP_CLICK, COORD_MAX, '0, '0, '0);
		// inverted in x, then inverted in y: take a slot, never hit
		queue_item(OP_LOAD, COORD_MAX, '0, '0, COORD_MAX);
		queue_item(OP_LOAD, '0, COORD_MAX, COORD_MAX, '0);
		queue_item(OP_CLICK, 12'd2000, '0, COORD_MAX, COORD_MAX);
		// single point windows at both extreme corners
		queue_item(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_item(OP_LOAD, '0, '0, '0, '0);
		queue_item(OP_CLICK, COORD_MAX, COORD_MAX, '0, '0);
		queue_item(OP_CLICK, '0, '0, '0, '0);
		// ordinary window, hit on its top right corner, miss just left of it
		queue_item(OP_LOAD, 12'd100, 12'd200, 12'd300, 12'd400);
		queue_item(OP_CLICK, 12'd300, 12'd400, '0, '0);
		queue_item(OP_CLICK, 12'd99, 12'd200, '0, '0);
		// fill the rest of the stack with random overlapping windows
		for (i = 0; i < STACK_DEPTH - 6; i++) begin
			lo_x = COORD_W'($urandom_range(0, 4095));
			lo_y = COORD_W'($urandom_range(0, 4095));
			wid = $urandom_range(0, 1500);
			hi_x = (lo_x + wid > 4095) ? COORD_MAX : COORD_W'(lo_x + wid);
			wid = $urandom_range(0, 1500);
			hi_y = (lo_y + wid > 4095) ? COORD_MAX : COORD_W'(lo_y + wid);
			queue_item(OP_LOAD, lo_x, lo_y, hi_x, hi_y);
		end
		// load into a full stack is dropped
		queue_item(OP_LOAD, 12'd1, 12'd1, COORD_MAX, COORD_MAX);
		queue_item(OP_CLICK, 12'd150, 12'd300, COORD_MAX, 12'd1234);

		// random: mostly clicks aimed at known windows, some noise
		while (clicks_planned < CLICK_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// dropped load with random content
				queue_item(OP_LOAD, COORD_W'($urandom_range(0, 4095)),
					COORD_W'($urandom_range(0, 4095)),
					COORD_W'($urandom_range(0, 4095)),
					COORD_W'($urandom_range(0, 4095)));
			end else begin
				r = aim_rects[$urandom_range(0, STACK_DEPTH - 1)];
				lo_x = (r.left < r.right) ? r.left : r.right;
				hi_x = (r.left < r.right) ? r.right : r.left;
				lo_y = (r.bottom < r.top) ? r.bottom : r.top;
				hi_y = (r.bottom < r.top) ? r.top : r.bottom;
				if (pick < 60) begin
					// inside the box
					cx = COORD_W'($urandom_range(lo_x, hi_x));
					cy = COORD_W'($urandom_range(lo_y, hi_y));
				end else if (pick < 80) begin
					// on an edge or one past it, wraps at the coordinate limits
					case ($urandom_range(0, 3))
						0: cx = r.left;
						1: cx = r.right;
						2: cx = r.left - 1'b1;
						default: cx = r.right + 1'b1;
					endcase
					case ($urandom_range(0, 3))
						0: cy = r.bottom;
						1: cy = r.top;
						2: cy = r.bottom - 1'b1;
						default: cy = r.top + 1'b1;
					endcase
				end else begin
					cx = COORD_W'($urandom_range(0, 4095));
					cy = COORD_W'($urandom_range(0, 4095));
				end
				queue_item(OP_CLICK, cx, cy, COORD_W'($urandom_range(0, 4095)),
					COORD_W'($urandom_range(0, 4095)));
			end
		end

		// reset once, released at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// everything sent and every click answered, then let the block settle
		while (stim_q.size() != 0 || in_valid || click_results_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d clicks (%0d hits, %0d misses) under random stalls",
			clicks_done, hits_done, clicks_done - hits_done);
		$display("stack loads kept %0d, loads refused on a full stack %0d, mismatches %0d",
			loads_kept, loads_dropped, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
